>>> src/crt_two_moduli_solver_macros.svh
// ----------------------------------------------------------------------------
// crt_two_moduli_solver_macros.svh
// Assertion macros used by the checker file of the two-moduli solver.
// ----------------------------------------------------------------------------
`ifndef CRT_TWO_MODULI_SOLVER_MACROS_SVH
`define CRT_TWO_MODULI_SOLVER_MACROS_SVH

// Checked only while out of reset
`define CRT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) cond) else $error(msg);

// Checked at every edge, reset included
`define CRT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) cond) else $error(msg);

`endif

>>> src/crt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crt_pkg
// Shared constants and types of the two-moduli remainder solver.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int CRT_MODULUS_BITS  = 16;
  localparam int CRT_SOLUTION_BITS = 32;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EG_DIV,
    S_EG_MUL,
    S_EG_UPD,
    S_CHK_DIV,
    S_MG_DIV,
    S_A_DIV,
    S_X_DIV,
    S_K_MUL,
    S_K_DIV,
    S_NG_DIV,
    S_LCM_MUL,
    S_NK_MUL,
    S_T_DIV,
    S_T_ADD,
    S_DONE
  } crt_state_t;

  // Divider request
  typedef struct packed {
    logic start;
    logic short_op;
  } crt_div_req_t;

endpackage
`default_nettype wire

>>> src/crt_two_moduli_solver.sv
// ----------------------------------------------------------------------------
// crt_two_moduli_solver
// Generalized Chinese remainder solver for two moduli (not necessarily coprime).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: two residues and two moduli per item. An item is taken
//   when in_valid is high and in_stall is low. in_stall is high from the item's
//   acceptance until its result has been loaded into the output register.
//   Result channel out_*: out_status (0 found, 1 incompatible or zero modulus)
//   and out_solution (t below the lcm, low 32 bits; 0 when none).
//   Steps: each extended Euclid step runs one division on the shared
//   bit-serial divider, then a multiply and an update; the tail takes six
//   short divisions, one long division, three multiplies and an add. The
//   time an item takes is set by the number of Euclid steps through the
//   divider. One item is in work at a time.
//   Reset (rst_n low, synchronous) returns to idle and drops out_valid.
//   If out_stall holds a result, the next result waits in the final state
//   and no new item is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
module crt_two_moduli_solver #(
  parameter int MODULUS_BITS = crt_pkg::CRT_MODULUS_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [MODULUS_BITS-1:0] in_first_residue,
  input  logic [MODULUS_BITS-1:0] in_first_modulus,
  input  logic [MODULUS_BITS-1:0] in_second_residue,
  input  logic [MODULUS_BITS-1:0] in_second_modulus,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_status,
  output logic [crt_pkg::CRT_SOLUTION_BITS-1:0] out_solution
);

  import crt_pkg::*;

  localparam int W  = MODULUS_BITS;
  localparam int DW = 2 * W;
  localparam int SW = W + 2;
  localparam int PW = DW + 3;
  localparam int TW = (DW > CRT_SOLUTION_BITS) ? DW : CRT_SOLUTION_BITS;

  crt_state_t state_r, state_nxt;
  logic       sub_r, sub_nxt;
  logic       fail_r, fail_nxt;

  logic [W-1:0] a_r, a_nxt, n_r, n_nxt, b_r, b_nxt, m_r, m_nxt;
  logic [W-1:0] r0_r, r0_nxt, r1_r, r1_nxt;
  logic signed [SW-1:0] s0_r, s0_nxt, s1_r, s1_nxt;
  logic [W-1:0] quo_r, quo_nxt, erem_r, erem_nxt;
  logic [W-1:0] dq_r, dq_nxt, mg_r, mg_nxt;
  logic [W-1:0] ra_r, ra_nxt, rb_r, rb_nxt, k_r, k_nxt, ng_r, ng_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic [DW-1:0] lcm_r, lcm_nxt, nk_r, nk_nxt, ar_r, ar_nxt, t_r, t_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_status_r, out_status_nxt;
  logic [CRT_SOLUTION_BITS-1:0] out_solution_r, out_solution_nxt;

  // Divider interface
  crt_div_req_t  div_req;
  logic [DW-1:0] div_dvd, div_dvs, div_quo, div_rem;
  logic          div_done;

  // Shared multiplier
  logic signed [W:0]    mul_x;
  logic signed [SW-1:0] mul_y;
  logic signed [PW-1:0] mul_p;

  // Signed helpers
  logic [W:0]    diff;
  logic          dneg, xneg;
  logic [W-1:0]  absd;
  logic [SW-1:0] negx;
  logic [W:0]    absx;
  logic [W-1:0]  red_r;
  logic [DW:0]   t_sum;
  logic [TW-1:0] t_ext;
  logic          is_div_state;

  assign diff  = {1'b0, b_r} - {1'b0, a_r};
  assign dneg  = diff[W];
  assign absd  = dneg ? W'(-diff) : diff[W-1:0];
  assign xneg  = s0_r[SW-1];
  assign negx  = -s0_r;
  assign absx  = xneg ? negx[W:0] : s0_r[W:0];
  assign red_r = div_rem[W-1:0];
  assign t_sum = {1'b0, ar_r} + {1'b0, nk_r};
  assign t_ext = TW'(t_r);

  // Multiplier operand select
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state_r)
      S_EG_MUL: begin
        mul_x = {1'b0, quo_r};
        mul_y = s1_r;
      end
      S_K_MUL: begin
        mul_x = {1'b0, ra_r};
        mul_y = {2'b00, rb_r};
      end
      S_LCM_MUL: begin
        mul_x = {1'b0, ng_r};
        mul_y = {2'b00, m_r};
      end
      S_NK_MUL: begin
        mul_x = {1'b0, n_r};
        mul_y = {2'b00, k_r};
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p = mul_x * mul_y;

  // Divider operand select
  always_comb begin
    div_dvd          = '0;
    div_dvs          = '0;
    div_req.short_op = 1'b1;
    is_div_state     = 1'b1;
    case (state_r)
      S_EG_DIV: begin
        div_dvd = DW'(r0_r);
        div_dvs = DW'(r1_r);
      end
      S_CHK_DIV: begin
        div_dvd = DW'(absd);
        div_dvs = DW'(r0_r);
      end
      S_MG_DIV: begin
        div_dvd = DW'(m_r);
        div_dvs = DW'(r0_r);
      end
      S_A_DIV: begin
        div_dvd = DW'(dq_r);
        div_dvs = DW'(mg_r);
      end
      S_X_DIV: begin
        div_dvd = DW'(absx);
        div_dvs = DW'(mg_r);
      end
      S_K_DIV: begin
        div_dvd          = prod_r[DW-1:0];
        div_dvs          = DW'(mg_r);
        div_req.short_op = 1'b0;
      end
      S_NG_DIV: begin
        div_dvd = DW'(n_r);
        div_dvs = DW'(r0_r);
      end
      S_T_DIV: begin
        div_dvd = DW'(a_r);
        div_dvs = lcm_r;
      end
      default: begin
        is_div_state = 1'b0;
      end
    endcase
    // Euclid loop ends without a division once the remainder is zero
    div_req.start = is_div_state && !sub_r &&
                    !((state_r == S_EG_DIV) && (r1_r == '0));
  end

  crt_div #(
    .DIV_BITS   (DW),
    .SHORT_BITS (W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt        = state_r;
    sub_nxt          = sub_r;
    fail_nxt         = fail_r;
    a_nxt            = a_r;
    n_nxt            = n_r;
    b_nxt            = b_r;
    m_nxt            = m_r;
    r0_nxt           = r0_r;
    r1_nxt           = r1_r;
    s0_nxt           = s0_r;
    s1_nxt           = s1_r;
    quo_nxt          = quo_r;
    erem_nxt         = erem_r;
    dq_nxt           = dq_r;
    mg_nxt           = mg_r;
    ra_nxt           = ra_r;
    rb_nxt           = rb_r;
    k_nxt            = k_r;
    ng_nxt           = ng_r;
    prod_nxt         = prod_r;
    lcm_nxt          = lcm_r;
    nk_nxt           = nk_r;
    ar_nxt           = ar_r;
    t_nxt            = t_r;
    out_status_nxt   = out_status_r;
    out_solution_nxt = out_solution_r;
    out_valid_nxt    = out_valid_r && out_stall;

    // Launch / wait handshake of the divider
    if (div_req.start) begin
      sub_nxt = 1'b1;
    end else if (div_done) begin
      sub_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          a_nxt    = in_first_residue;
          n_nxt    = in_first_modulus;
          b_nxt    = in_second_residue;
          m_nxt    = in_second_modulus;
          r0_nxt   = in_first_modulus;
          r1_nxt   = in_second_modulus;
          s0_nxt   = SW'(1);
          s1_nxt   = '0;
          fail_nxt = (in_first_modulus == '0) || (in_second_modulus == '0);
          state_nxt = fail_nxt ? S_DONE : S_EG_DIV;
        end
      end
      S_EG_DIV: begin
        if (!sub_r && (r1_r == '0)) begin
          state_nxt = S_CHK_DIV;
        end else if (div_done) begin
          quo_nxt   = div_quo[W-1:0];
          erem_nxt  = red_r;
          state_nxt = S_EG_MUL;
        end
      end
      S_EG_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_EG_UPD;
      end
      S_EG_UPD: begin
        r0_nxt    = r1_r;
        r1_nxt    = erem_r;
        s0_nxt    = s1_r;
        s1_nxt    = s0_r - prod_r[SW-1:0];
        state_nxt = S_EG_DIV;
      end
      S_CHK_DIV: begin
        if (div_done) begin
          if (div_rem != '0) begin
            fail_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            dq_nxt    = div_quo[W-1:0];
            state_nxt = S_MG_DIV;
          end
        end
      end
      S_MG_DIV: begin
        if (div_done) begin
          mg_nxt    = div_quo[W-1:0];
          state_nxt = S_A_DIV;
        end
      end
      S_A_DIV: begin
        if (div_done) begin
          ra_nxt    = (dneg && (red_r != '0)) ? (mg_r - red_r) : red_r;
          state_nxt = S_X_DIV;
        end
      end
      S_X_DIV: begin
        if (div_done) begin
          rb_nxt    = (xneg && (red_r != '0)) ? (mg_r - red_r) : red_r;
          state_nxt = S_K_MUL;
        end
      end
      S_K_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_K_DIV;
      end
      S_K_DIV: begin
        if (div_done) begin
          k_nxt     = red_r;
          state_nxt = S_NG_DIV;
        end
      end
      S_NG_DIV: begin
        if (div_done) begin
          ng_nxt    = div_quo[W-1:0];
          state_nxt = S_LCM_MUL;
        end
      end
      S_LCM_MUL: begin
        lcm_nxt   = mul_p[DW-1:0];
        state_nxt = S_NK_MUL;
      end
      S_NK_MUL: begin
        nk_nxt    = mul_p[DW-1:0];
        state_nxt = S_T_DIV;
      end
      S_T_DIV: begin
        if (div_done) begin
          ar_nxt    = div_rem;
          state_nxt = S_T_ADD;
        end
      end
      S_T_ADD: begin
        // sum stays below twice the lcm
        t_nxt     = (t_sum >= {1'b0, lcm_r}) ? DW'(t_sum - {1'b0, lcm_r}) : t_sum[DW-1:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_status_nxt   = fail_r;
          out_solution_nxt = fail_r ? '0 : t_ext[CRT_SOLUTION_BITS-1:0];
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sub_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    fail_r         <= fail_nxt;
    a_r            <= a_nxt;
    n_r            <= n_nxt;
    b_r            <= b_nxt;
    m_r            <= m_nxt;
    r0_r           <= r0_nxt;
    r1_r           <= r1_nxt;
    s0_r           <= s0_nxt;
    s1_r           <= s1_nxt;
    quo_r          <= quo_nxt;
    erem_r         <= erem_nxt;
    dq_r           <= dq_nxt;
    mg_r           <= mg_nxt;
    ra_r           <= ra_nxt;
    rb_r           <= rb_nxt;
    k_r            <= k_nxt;
    ng_r           <= ng_nxt;
    prod_r         <= prod_nxt;
    lcm_r          <= lcm_nxt;
    nk_r           <= nk_nxt;
    ar_r           <= ar_nxt;
    t_r            <= t_nxt;
    out_status_r   <= out_status_nxt;
    out_solution_r <= out_solution_nxt;
  end

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_solution = out_solution_r;

endmodule
`default_nettype wire

>>> src/crt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crt_div
// Shared restoring divider, one quotient bit per cycle. A short request
// treats the dividend as SHORT_BITS wide.
// ----------------------------------------------------------------------------
module crt_div #(
  parameter int DIV_BITS   = 2 * crt_pkg::CRT_MODULUS_BITS,
  parameter int SHORT_BITS = crt_pkg::CRT_MODULUS_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  crt_pkg::crt_div_req_t req,
  input  logic [DIV_BITS-1:0]   dividend,
  input  logic [DIV_BITS-1:0]   divisor,
  output logic [DIV_BITS-1:0]   quotient,
  output logic [DIV_BITS-1:0]   remainder,
  output logic                  done
);

  localparam int CW = $clog2(DIV_BITS + 1);

  logic [DIV_BITS-1:0] rem_r, rem_nxt;
  logic [DIV_BITS-1:0] shf_r, shf_nxt;
  logic [DIV_BITS-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;

  logic [DIV_BITS:0]   trial;
  logic [DIV_BITS:0]   trial_sub;
  logic                fits;

  // Trial subtract of the partial remainder
  assign trial     = {rem_r, shf_r[DIV_BITS-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign fits      = (trial >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt  = rem_r;
    shf_nxt  = shf_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      shf_nxt  = req.short_op ? (dividend << SHORT_BITS) : dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = req.short_op ? CW'(SHORT_BITS) : CW'(DIV_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? trial_sub[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      shf_nxt = {shf_r[DIV_BITS-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    shf_r <= shf_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = shf_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule
`default_nettype wire

>>> src/crt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crt_checker
// Port-level assertions for the two-moduli solver, bound to the top level.
// ----------------------------------------------------------------------------
`include "crt_two_moduli_solver_macros.svh"

module crt_checker #(
  parameter int MODULUS_BITS = crt_pkg::CRT_MODULUS_BITS
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic [MODULUS_BITS-1:0] in_first_residue,
  input wire logic [MODULUS_BITS-1:0] in_first_modulus,
  input wire logic [MODULUS_BITS-1:0] in_second_residue,
  input wire logic [MODULUS_BITS-1:0] in_second_modulus,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic                    out_status,
  input wire logic [crt_pkg::CRT_SOLUTION_BITS-1:0] out_solution
);

  // Reset drops any pending result
  `CRT_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "out_valid after reset")

  // A held result keeps its payload
  `CRT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_solution) && $stable(out_status), "stalled result changed")

  // No solution means a zero value
  `CRT_ASSERT(a_fail_zero, out_valid && out_status |-> out_solution == '0, "nonzero value on failure")

  // The block is busy right after taking an item
  `CRT_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "not busy after accept")

endmodule

bind crt_two_moduli_solver crt_checker #(
  .MODULUS_BITS (MODULUS_BITS)
) u_crt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_first_residue  (in_first_residue),
  .in_first_modulus  (in_first_modulus),
  .in_second_residue (in_second_residue),
  .in_second_modulus (in_second_modulus),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_solution      (out_solution)
);
`default_nettype wire
